@@ hdl/srb_pkg.sv @@
// shared types and constants for the bitmap shape rasterizer
package srb_pkg;

  localparam int DEF_CANVAS_ROWS = 32;
  localparam int DEF_CANVAS_COLS = 64;

  localparam int ROW_BITS_W = 64;  // width of one canvas row word
  localparam int ROW_IDX_W  = 6;   // width of an emitted row number
  localparam int SQ_W       = 20;  // squares and ring accumulator
  localparam int DELTA_W    = 10;  // signed pixel offsets

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_ROW = 1'b1;

  typedef enum logic [2:0] {
    OP_RECT    = 3'd0,
    OP_LINE    = 3'd1,
    OP_TRI     = 3'd2,
    OP_CIRCLE  = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_DISPLAY = 3'd5
  } srb_op_t;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [7:0] row_coord;
    logic signed [7:0] col_coord;
    logic signed [7:0] extent_a;
    logic signed [7:0] extent_b;
  } srb_cmd_t;

  typedef struct packed {
    logic                  kind;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last;
  } srb_res_t;

  typedef enum logic [1:0] {
    MUL_RAD = 2'd0,
    MUL_COL = 2'd1,
    MUL_ROW = 2'd2
  } srb_mul_sel_t;

  typedef struct packed {
    logic         mul_en;
    srb_mul_sel_t mul_sel;
    logic         init;
    logic         step;
  } srb_ring_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_RAD,
    S_SQ_COL,
    S_ROW_RD,
    S_RING_INIT,
    S_RING_PIX,
    S_ROW_WR,
    S_ACK,
    S_DISP_RD,
    S_DISP_OUT
  } srb_state_t;

endpackage

@@ hdl/srb_ram.sv @@
// generic single-write, single-read ram with registered read data
module srb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/srb_span_mask.sv @@
// row mask for rectangle, line and triangle outlines
module srb_span_mask #(
  parameter int CANVAS_COLS = srb_pkg::DEF_CANVAS_COLS
) (
  input  srb_pkg::srb_cmd_t                 cmd,
  input  logic [srb_pkg::ROW_IDX_W-1:0]     row,
  output logic [srb_pkg::ROW_BITS_W-1:0]    mask
);

  import srb_pkg::*;

  // columns lo..hi inside the canvas
  function automatic logic [ROW_BITS_W-1:0] span(input logic signed [10:0] lo,
                                                  input logic signed [10:0] hi);
    logic [ROW_BITS_W-1:0] m;
    logic signed [10:0]    jj;
    m = '0;
    for (int j = 0; j < ROW_BITS_W; j++) begin
      jj = signed'(11'(j));
      if (j < CANVAS_COLS) begin
        m[j] = (jj >= lo) && (jj <= hi);
      end
    end
    return m;
  endfunction

  logic signed [10:0] ri, r, c, a, b, k;
  logic signed [10:0] lo1, hi1, lo2, hi2;
  logic               en1, en2;

  always_comb begin
    ri = signed'({5'b0, row});
    r  = 11'(cmd.row_coord);
    c  = 11'(cmd.col_coord);
    a  = 11'(cmd.extent_a);
    b  = 11'(cmd.extent_b);
    k  = ri - r;
    en1 = 1'b0;
    en2 = 1'b0;
    lo1 = c;
    hi1 = c;
    lo2 = c;
    hi2 = c;
    case (cmd.op)
      OP_RECT: begin
        if (a > 0 && b > 0 && ri >= r && ri <= r + b - 11'sd1) begin
          en1 = 1'b1;
          if (ri == r || ri == r + b - 11'sd1) begin
            hi1 = c + a - 11'sd1;
          end else begin
            en2 = 1'b1;
            lo2 = c + a - 11'sd1;
            hi2 = c + a - 11'sd1;
          end
        end
      end
      OP_LINE: begin
        if (r == a) begin
          // horizontal
          en1 = (ri == r);
          lo1 = (c < b) ? c : b;
          hi1 = (c < b) ? b : c;
        end else if (c == b) begin
          // vertical
          en1 = (ri >= ((r < a) ? r : a)) && (ri <= ((r < a) ? a : r));
        end
      end
      OP_TRI: begin
        if (a > 0 && k >= 0 && k <= a - 11'sd1) begin
          en1 = 1'b1;
          if (k == a - 11'sd1) begin
            hi1 = c + k;
          end else begin
            en2 = 1'b1;
            lo2 = c + k;
            hi2 = c + k;
          end
        end
      end
      default: begin
        en1 = 1'b0;
      end
    endcase
    mask = (en1 ? span(lo1, hi1) : '0) | (en2 ? span(lo2, hi2) : '0);
  end

endmodule

@@ hdl/srb_ring_unit.sv @@
// shared squarer and per-pixel ring distance walker for circles
module srb_ring_unit (
  input  logic                          clk,
  input  srb_pkg::srb_ring_ctl_t        ctl,
  input  srb_pkg::srb_cmd_t             cmd,
  input  logic [srb_pkg::ROW_IDX_W-1:0] row,
  output logic                          hit
);

  import srb_pkg::*;

  logic signed [DELTA_W-1:0] mul_x;
  logic signed [SQ_W-1:0]    prod;
  logic signed [SQ_W-1:0]    asq, csq, dx2, acc;
  logic signed [DELTA_W-1:0] dy;
  logic signed [SQ_W-1:0]    rad;
  logic signed [SQ_W-1:0]    stride;

  always_comb begin
    case (ctl.mul_sel)
      MUL_RAD: mul_x = DELTA_W'(cmd.extent_a);
      MUL_COL: mul_x = DELTA_W'(cmd.col_coord);
      default: mul_x = signed'(DELTA_W'(row)) - DELTA_W'(cmd.row_coord);
    endcase
    prod   = SQ_W'(mul_x) * SQ_W'(mul_x);
    rad    = SQ_W'(cmd.extent_a);
    // (dy+1)^2 - dy^2
    stride = SQ_W'(signed'({dy, 1'b1}));
    hit    = (rad > 0) && (acc < rad) && (acc > -rad);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      case (ctl.mul_sel)
        MUL_RAD: asq <= prod;
        MUL_COL: csq <= prod;
        default: dx2 <= prod;
      endcase
    end
    if (ctl.init) begin
      acc <= dx2 - asq + csq;
      dy  <= -DELTA_W'(cmd.col_coord);
    end else if (ctl.step) begin
      acc <= acc + stride;
      dy  <= dy + DELTA_W'(1);
    end
  end

endmodule

@@ hdl/shape_rasterizer_bitmap_core.sv @@
// top level of the bitmap shape rasterizer: sequencer, canvas ram and result register
//
// usage
// - cmd channel: one item per command (rectangle, line, triangle, circle,
//   clear, display); taken when cmd_valid is high and cmd_stall low
// - res channel: rectangle, line, triangle, circle, clear and unknown ops
//   each return one ack item (kind 0, last 1); display returns one item
//   per canvas row, in row order, last set on the final row
// - cmd_stall is high while a command is in progress; one command at a time
// - steps per command, C = CANVAS_COLS:
//     rectangle, line, triangle: read then write each row, then the ack
//     circle: per row a read, C pixels one per cycle through the ring unit, a write
//     clear and unknown ops: the ack only
//     display: per row a registered ram read, then the row item
// - the canvas ram has one write and one read port; a valid flag per row
//   marks rows written since reset or clear, other rows read as zero,
//   so reset and clear take effect at once with no sweep
// - a stalled result holds in the output register; the sequencer waits on
//   the ack or the next display row until the register frees up
// - rst is synchronous, active high; it empties the canvas and result register
module shape_rasterizer_bitmap_core #(
  parameter int CANVAS_ROWS = srb_pkg::DEF_CANVAS_ROWS,
  parameter int CANVAS_COLS = srb_pkg::DEF_CANVAS_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  srb_pkg::srb_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output srb_pkg::srb_res_t res
);

  import srb_pkg::*;

  localparam int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
  localparam int COL_W = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(CANVAS_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(CANVAS_COLS - 1);

  srb_state_t state, state_next;
  srb_cmd_t   cmd_q;
  logic [ROW_W-1:0]      row, row_next;
  logic [COL_W-1:0]      col, col_next;
  logic [ROW_BITS_W-1:0] mask, mask_next;
  logic [CANVAS_ROWS-1:0] row_valid;

  // control strobes from the sequencer
  logic          mem_we;
  logic          valid_clr;
  logic          res_load;
  srb_res_t      res_item;
  srb_ring_ctl_t ring_ctl;

  logic [ROW_BITS_W-1:0] rdata, row_word, wdata, span_mask;
  logic                  ring_hit;
  logic                  res_free;

  // ram output gated by the row valid flag
  assign row_word  = row_valid[row] ? rdata : '0;
  assign wdata     = row_word | mask;
  assign res_free  = !res_valid || !res_stall;
  assign cmd_stall = (state != S_IDLE);

  srb_ram #(
    .WIDTH(ROW_BITS_W),
    .DEPTH(CANVAS_ROWS)
  ) u_canvas (
    .clk  (clk),
    .we   (mem_we),
    .waddr(row),
    .wdata(wdata),
    .raddr(row),
    .rdata(rdata)
  );

  srb_span_mask #(
    .CANVAS_COLS(CANVAS_COLS)
  ) u_span (
    .cmd (cmd_q),
    .row (ROW_IDX_W'(row)),
    .mask(span_mask)
  );

  srb_ring_unit u_ring (
    .clk(clk),
    .ctl(ring_ctl),
    .cmd(cmd_q),
    .row(ROW_IDX_W'(row)),
    .hit(ring_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    mask_next  = mask;
    mem_we     = 1'b0;
    valid_clr  = 1'b0;
    res_load   = 1'b0;
    res_item   = '0;
    ring_ctl   = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          row_next = '0;
          unique case (cmd.op) inside
            OP_RECT, OP_LINE, OP_TRI: state_next = S_ROW_RD;
            OP_CIRCLE:                state_next = S_SQ_RAD;
            OP_CLEAR: begin
              valid_clr  = 1'b1;
              state_next = S_ACK;
            end
            OP_DISPLAY:               state_next = S_DISP_RD;
            default:                  state_next = S_ACK;
          endcase
        end
      end
      // radius and centre column squares, once per circle
      S_SQ_RAD: begin
        ring_ctl.mul_en  = 1'b1;
        ring_ctl.mul_sel = MUL_RAD;
        state_next       = S_SQ_COL;
      end
      S_SQ_COL: begin
        ring_ctl.mul_en  = 1'b1;
        ring_ctl.mul_sel = MUL_COL;
        state_next       = S_ROW_RD;
      end
      // ram read issued here for the row; data lands in S_ROW_WR
      S_ROW_RD: begin
        if (cmd_q.op == OP_CIRCLE) begin
          ring_ctl.mul_en  = 1'b1;
          ring_ctl.mul_sel = MUL_ROW;
          state_next       = S_RING_INIT;
        end else begin
          mask_next  = span_mask;
          state_next = S_ROW_WR;
        end
      end
      S_RING_INIT: begin
        ring_ctl.init = 1'b1;
        col_next      = '0;
        mask_next     = '0;
        state_next    = S_RING_PIX;
      end
      // one pixel of the ring per cycle
      S_RING_PIX: begin
        ring_ctl.step = 1'b1;
        mask_next     = mask | (ROW_BITS_W'(ring_hit) << col);
        col_next      = col + 1'b1;
        if (col == COL_LAST) begin
          state_next = S_ROW_WR;
        end
      end
      S_ROW_WR: begin
        mem_we = 1'b1;
        if (row == ROW_LAST) begin
          state_next = S_ACK;
        end else begin
          row_next   = row + 1'b1;
          state_next = S_ROW_RD;
        end
      end
      S_ACK: begin
        if (res_free) begin
          res_load       = 1'b1;
          res_item.kind  = KIND_ACK;
          res_item.last  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DISP_RD: begin
        state_next = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        if (res_free) begin
          res_load           = 1'b1;
          res_item.kind      = KIND_ROW;
          res_item.row_index = ROW_IDX_W'(row);
          res_item.row_bits  = row_word;
          res_item.last      = (row == ROW_LAST);
          if (row == ROW_LAST) begin
            state_next = S_IDLE;
          end else begin
            row_next   = row + 1'b1;
            state_next = S_DISP_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_q <= cmd;
    end
    row  <= row_next;
    col  <= col_next;
    mask <= mask_next;
  end

  // row valid flags: cleared by reset and clear, set on each row write
  always_ff @(posedge clk) begin
    if (rst || valid_clr) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[row] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_item;
    end
  end

endmodule
